FILE: rtl/core/hbs_pkg.sv
// Shared types and constants for the heightmap bilinear sampler.
package hbs_pkg;

   // Grid geometry: cells live at row * MAX_SIDE + col, split over four parity banks
   localparam int unsigned MAX_SIDE = 128;
   localparam int unsigned SIDE_W   = $clog2(MAX_SIDE);
   localparam int unsigned SIZE_W   = $clog2(MAX_SIDE + 1);
   localparam int unsigned BANK_AW  = 2 * (SIDE_W - 1);
   localparam int unsigned CELL_W   = 16;
   localparam int unsigned FRAC_W   = 8;

   // CSR map
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_DEPTH  = 2'd1,
      CSR_INV_SCALE   = 2'd2,
      CSR_HEIGHT_GAIN = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_READ   = 2'd1,
      MODE_SAMPLE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_CHECK,
      ST_FETCH,
      ST_INTERP,
      ST_DONE
   } state_type;

   // Access to the cell store; col/row name the top-left corner of a sample
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [SIDE_W-1:0] col;
      logic [SIDE_W-1:0] row;
      logic [CELL_W-1:0] wdata;
   } store_cmd_type;

   // Four neighboring cells: hXZ with X the column offset and Z the row offset
   typedef struct packed {
      logic signed [CELL_W-1:0] h00;
      logic signed [CELL_W-1:0] h10;
      logic signed [CELL_W-1:0] h01;
      logic signed [CELL_W-1:0] h11;
   } corner_type;

endpackage

FILE: rtl/core/hbs_ram.sv
// Generic single-port synchronous RAM with a registered read.
module hbs_ram #(
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DATA_W = 16
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // Write or read one entry
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/hbs_store.sv
// Cell store split into four row/column parity banks so one read returns all four corners.
module hbs_store (
   input  logic                  clock,
   input  hbs_pkg::store_cmd_type cmd,
   output hbs_pkg::corner_type    corners
);

   logic [hbs_pkg::CELL_W-1:0] q [4];
   logic [1:0]                 par_ff;

   // One bank per parity pair; each bank picks the corner cell of its parity
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam int unsigned CP = b % 2;
      localparam int unsigned RP = b / 2;

      logic [hbs_pkg::SIDE_W-1:0]  col_sel;
      logic [hbs_pkg::SIDE_W-1:0]  row_sel;
      logic [hbs_pkg::BANK_AW-1:0] addr;
      logic                        hit;

      assign col_sel = (cmd.col[0] == 1'(CP)) ? cmd.col : cmd.col + 1'b1;
      assign row_sel = (cmd.row[0] == 1'(RP)) ? cmd.row : cmd.row + 1'b1;
      assign addr    = {row_sel[hbs_pkg::SIDE_W-1:1], col_sel[hbs_pkg::SIDE_W-1:1]};
      assign hit     = (cmd.col[0] == 1'(CP)) && (cmd.row[0] == 1'(RP));

      hbs_ram #(
         .ADDR_W (hbs_pkg::BANK_AW),
         .DATA_W (hbs_pkg::CELL_W)
      ) u_ram (
         .clock (clock),
         .en    (cmd.rd_en || (cmd.wr_en && hit)),
         .we    (cmd.wr_en && hit),
         .addr  (addr),
         .wdata (cmd.wdata),
         .rdata (q[b])
      );
   end

   // Remember base parity to route bank outputs back to corners
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         par_ff <= {cmd.row[0], cmd.col[0]};
      end
   end

   assign corners.h00 = q[{ par_ff[1],  par_ff[0]}];
   assign corners.h10 = q[{ par_ff[1], ~par_ff[0]}];
   assign corners.h01 = q[{~par_ff[1],  par_ff[0]}];
   assign corners.h11 = q[{~par_ff[1], ~par_ff[0]}];

endmodule

FILE: rtl/core/hbs_interp.sv
// Three-stage bilinear interpolation and gain datapath.
module hbs_interp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  hbs_pkg::corner_type        corners,
   input  logic [hbs_pkg::FRAC_W-1:0] fx,
   input  logic [hbs_pkg::FRAC_W-1:0] fz,
   input  logic [15:0]                gain,
   output logic                       done,
   output logic signed [31:0]         value
);

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [16:0] dtop, dbot;
   logic signed [25:0] ptop, pbot;
   logic [25:0]        top_in, bot_in, top_ff, bot_ff;
   logic [7:0]         fz_ff;
   logic signed [26:0] dz;
   logic signed [35:0] pz;
   logic [35:0]        acc_sum;
   logic [33:0]        acc_ff;
   logic signed [50:0] pg;
   logic [31:0]        value_ff;

   // Stage 1: blend along x, top = 256*h00 + fx*(h10-h00)
   assign dtop   = {corners.h10[15], corners.h10} - {corners.h00[15], corners.h00};
   assign dbot   = {corners.h11[15], corners.h11} - {corners.h01[15], corners.h01};
   assign ptop   = dtop * $signed({1'b0, fx});
   assign pbot   = dbot * $signed({1'b0, fx});
   assign top_in = ptop + {{2{corners.h00[15]}}, corners.h00, 8'b0};
   assign bot_in = pbot + {{2{corners.h01[15]}}, corners.h01, 8'b0};

   // Stage 2: blend along z
   assign dz      = {bot_ff[25], bot_ff} - {top_ff[25], top_ff};
   assign pz      = dz * $signed({1'b0, fz_ff});
   assign acc_sum = pz + {{2{top_ff[25]}}, top_ff, 8'b0};

   // Stage 3: apply gain, drop 20 fraction bits
   assign pg = $signed(acc_ff) * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (start) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fz_ff  <= fz;
      end
      if (v1_ff) begin
         acc_ff <= acc_sum[33:0];
      end
      if (v2_ff) begin
         value_ff <= {pg[50], pg[50:20]};
      end
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign done  = v3_ff;
   assign value = value_ff;

endmodule

FILE: rtl/core/heightmap_bilinear_sampler.sv
// Heightmap bilinear sampler top level: CSRs, transaction control and grid mapping.
//
// Handles one transaction at a time. A write passes through the bounds check and the
// store write; a read inside the grid through the bounds check, one bank read and the
// result; a sample outside the grid through the map multiply, the bounds check and the
// result; a sample inside the grid through the map multiply, bounds check, one bank read,
// three interpolation stages and the result. A finished result waits in an output register,
// so the next transaction is taken while it is pending; a second result waits until the
// first is taken. The store's four parity banks return all four corners of a sample
// in one read. Cells never written read back as undefined; there is no clearing pass.
module heightmap_bilinear_sampler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic signed [23:0]                 req_world_x,
   input  logic signed [23:0]                 req_world_z,
   input  logic [hbs_pkg::SIDE_W-1:0]         req_cell_col,
   input  logic [hbs_pkg::SIDE_W-1:0]         req_cell_row,
   input  logic signed [hbs_pkg::CELL_W-1:0]  req_cell_height,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_sample_value,
   output logic                               rsp_in_bounds,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [hbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int unsigned SW = hbs_pkg::SIDE_W;
   localparam int unsigned ZW = hbs_pkg::SIZE_W;

   // Configuration
   logic [7:0]  grid_width_ff, grid_depth_ff;
   logic [23:0] inv_scale_ff;
   logic [15:0] height_gain_ff;
   logic [ZW-1:0] w_eff, d_eff;

   // Transaction fields
   hbs_pkg::mode_type         mode_ff;
   logic signed [23:0]        world_x_ff, world_z_ff;
   logic [SW-1:0]             col_ff, row_ff;
   logic [hbs_pkg::CELL_W-1:0] height_ff;

   // Grid mapping
   logic signed [48:0] prod_x_ff, prod_z_ff;
   logic [33:0]        gx, gz;
   logic [15:0]        lim_x, lim_z;
   logic               pos_inb, cell_inb;
   logic [7:0]         fx_ff, fz_ff;

   // Control and result
   hbs_pkg::state_type     state_ff, state_in;
   hbs_pkg::store_cmd_type cmd;
   hbs_pkg::corner_type    corners;
   logic                   interp_start, interp_done, load_out;
   logic signed [31:0]     interp_value;
   logic [31:0]            res_value_ff, res_value_in;
   logic                   res_inb_ff, res_inb_in;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_value_ff;
   logic                   rsp_inb_ff;
   logic                   csr_wr;

   // CSR write and read
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 8'd128;
         grid_depth_ff  <= 8'd128;
         inv_scale_ff   <= 24'd65536;
         height_gain_ff <= 16'd256;
      end else if (csr_wr) begin
         unique case (hbs_pkg::csr_reg_type'(paddr[3:2]))
            hbs_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= pwdata[7:0];
            hbs_pkg::CSR_GRID_DEPTH:  grid_depth_ff  <= pwdata[7:0];
            hbs_pkg::CSR_INV_SCALE:   inv_scale_ff   <= pwdata[23:0];
            hbs_pkg::CSR_HEIGHT_GAIN: height_gain_ff <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (hbs_pkg::csr_reg_type'(paddr[3:2]))
         hbs_pkg::CSR_GRID_WIDTH:  prdata = {24'b0, grid_width_ff};
         hbs_pkg::CSR_GRID_DEPTH:  prdata = {24'b0, grid_depth_ff};
         hbs_pkg::CSR_INV_SCALE:   prdata = {8'b0, inv_scale_ff};
         hbs_pkg::CSR_HEIGHT_GAIN: prdata = {16'b0, height_gain_ff};
      endcase
   end

   // Clamp sizes to the store side
   assign w_eff = (grid_width_ff > 8'(hbs_pkg::MAX_SIDE)) ? ZW'(hbs_pkg::MAX_SIDE)
                                                         : ZW'(grid_width_ff);
   assign d_eff = (grid_depth_ff > 8'(hbs_pkg::MAX_SIDE)) ? ZW'(hbs_pkg::MAX_SIDE)
                                                         : ZW'(grid_depth_ff);

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff    <= hbs_pkg::mode_type'(req_mode);
         world_x_ff <= req_world_x;
         world_z_ff <= req_world_z;
         col_ff     <= req_cell_col;
         row_ff     <= req_cell_row;
         height_ff  <= req_cell_height;
      end
   end

   // World to grid: multiply by reciprocal scale
   always_ff @(posedge clock) begin
      if (state_ff == hbs_pkg::ST_MAP) begin
         prod_x_ff <= world_x_ff * $signed({1'b0, inv_scale_ff});
         prod_z_ff <= world_z_ff * $signed({1'b0, inv_scale_ff});
      end
   end

   // Keep 8 fraction bits and recenter on the grid
   assign gx = {prod_x_ff[48], prod_x_ff[48:16]} + {{(34 - ZW - 7){1'b0}}, w_eff, 7'b0};
   assign gz = {prod_z_ff[48], prod_z_ff[48:16]} + {{(34 - ZW - 7){1'b0}}, d_eff, 7'b0};
   assign lim_x = {8'(w_eff - 1'b1), 8'b0};
   assign lim_z = {8'(d_eff - 1'b1), 8'b0};

   assign pos_inb = (w_eff >= ZW'(2)) && (d_eff >= ZW'(2))
                 && !gx[33] && (gx[32:0] < {17'b0, lim_x})
                 && !gz[33] && (gz[32:0] < {17'b0, lim_z});
   assign cell_inb = ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < d_eff);

   always_ff @(posedge clock) begin
      if (state_ff == hbs_pkg::ST_CHECK) begin
         fx_ff <= gx[7:0];
         fz_ff <= gz[7:0];
      end
   end

   // Sequencer: next state, store access and result selection
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      interp_start = 1'b0;
      load_out     = 1'b0;
      res_value_in = res_value_ff;
      res_inb_in   = res_inb_ff;
      unique case (state_ff)
         hbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (hbs_pkg::mode_type'(req_mode)) inside
                  hbs_pkg::MODE_WRITE, hbs_pkg::MODE_READ: state_in = hbs_pkg::ST_CHECK;
                  hbs_pkg::MODE_SAMPLE: state_in = hbs_pkg::ST_MAP;
                  hbs_pkg::MODE_NONE:   state_in = hbs_pkg::ST_IDLE;
               endcase
            end
         end
         hbs_pkg::ST_MAP: begin
            state_in = hbs_pkg::ST_CHECK;
         end
         hbs_pkg::ST_CHECK: begin
            cmd.wdata = height_ff;
            if (mode_ff == hbs_pkg::MODE_SAMPLE) begin
               cmd.col = gx[SW+7:8];
               cmd.row = gz[SW+7:8];
            end else begin
               cmd.col = col_ff;
               cmd.row = row_ff;
            end
            unique case (mode_ff)
               hbs_pkg::MODE_WRITE: begin
                  cmd.wr_en = cell_inb;
                  state_in  = hbs_pkg::ST_IDLE;
               end
               hbs_pkg::MODE_READ: begin
                  if (cell_inb) begin
                     cmd.rd_en = 1'b1;
                     state_in  = hbs_pkg::ST_FETCH;
                  end else begin
                     res_value_in = '0;
                     res_inb_in   = 1'b0;
                     state_in     = hbs_pkg::ST_DONE;
                  end
               end
               hbs_pkg::MODE_SAMPLE: begin
                  if (pos_inb) begin
                     cmd.rd_en = 1'b1;
                     state_in  = hbs_pkg::ST_FETCH;
                  end else begin
                     res_value_in = '0;
                     res_inb_in   = 1'b0;
                     state_in     = hbs_pkg::ST_DONE;
                  end
               end
               hbs_pkg::MODE_NONE: begin
                  state_in = hbs_pkg::ST_IDLE;
               end
            endcase
         end
         hbs_pkg::ST_FETCH: begin
            if (mode_ff == hbs_pkg::MODE_SAMPLE) begin
               interp_start = 1'b1;
               state_in     = hbs_pkg::ST_INTERP;
            end else begin
               // Q4.12 cell to Q16.16
               res_value_in = {{12{corners.h00[15]}}, corners.h00, 4'b0};
               res_inb_in   = 1'b1;
               state_in     = hbs_pkg::ST_DONE;
            end
         end
         hbs_pkg::ST_INTERP: begin
            if (interp_done) begin
               res_value_in = interp_value;
               res_inb_in   = 1'b1;
               state_in     = hbs_pkg::ST_DONE;
            end
         end
         hbs_pkg::ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = hbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_inb_ff   <= res_inb_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_value_ff <= res_value_ff;
         rsp_inb_ff   <= res_inb_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_in_bounds    = rsp_inb_ff;

   hbs_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .corners (corners)
   );

   hbs_interp u_interp (
      .clock   (clock),
      .reset   (reset),
      .start   (interp_start),
      .corners (corners),
      .fx      (fx_ff),
      .fz      (fz_ff),
      .gain    (height_gain_ff),
      .done    (interp_done),
      .value   (interp_value)
   );

endmodule

FILE: rtl/core/hbs_checker.sv
// Port-level checks for the heightmap bilinear sampler, bound to the top level.
module hbs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [1:0]                         req_mode,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [31:0]                 rsp_sample_value,
   input logic                               rsp_in_bounds
);

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_value)
                                  && $stable(rsp_in_bounds))
      else $error("result changed while stalled");

   // A miss always reports zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_bounds |-> rsp_sample_value == 32'sd0)
      else $error("out-of-grid result is not zero");

   // Any real transaction keeps the block busy the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode != 2'(hbs_pkg::MODE_NONE)) |=> !req_ready)
      else $error("new transaction taken while busy");

   // Reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);

FILE: sim/tb.sv
// Testbench for the heightmap bilinear sampler: directed and random traffic, self-checking.
`timescale 1ns / 100ps

module tb;

   localparam int CLK_HALF   = 4;
   localparam int SETTLE_CYC = 16;
   localparam int FILL_SIDE  = 20;
   localparam int CELLS      = int'(hbs_pkg::MAX_SIDE * hbs_pkg::MAX_SIDE);

   typedef struct {
      hbs_pkg::mode_type  mode;
      logic signed [23:0] wx;
      logic signed [23:0] wz;
      logic [6:0]         col;
      logic [6:0]         row;
      logic signed [15:0] height;
   } terrain_query_type;

   typedef struct {
      logic signed [31:0] value;
      logic               in_bounds;
   } height_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid       = 1'b0;
   logic                              req_ready;
   logic [1:0]                        req_mode        = hbs_pkg::MODE_NONE;
   logic signed [23:0]                req_world_x     = '0;
   logic signed [23:0]                req_world_z     = '0;
   logic [hbs_pkg::SIDE_W-1:0]        req_cell_col    = '0;
   logic [hbs_pkg::SIDE_W-1:0]        req_cell_row    = '0;
   logic signed [hbs_pkg::CELL_W-1:0] req_cell_height = '0;
   logic                              rsp_valid;
   logic                              rsp_ready       = 1'b0;
   logic signed [31:0]                rsp_sample_value;
   logic                              rsp_in_bounds;
   logic                              psel            = 1'b0;
   logic                              penable         = 1'b0;
   logic                              pwrite          = 1'b0;
   logic [hbs_pkg::CSR_ADDR_W-1:0]    paddr           = '0;
   logic [hbs_pkg::CSR_DATA_W-1:0]    pwdata          = '0;
   logic [hbs_pkg::CSR_DATA_W-1:0]    prdata;
   logic                              pready;

   // Predictor state: register copies, the cell store and which cells hold data
   logic [7:0]         grid_width_r  = 8'd128;
   logic [7:0]         grid_depth_r  = 8'd128;
   logic [23:0]        inv_scale_r   = 24'd65536;
   logic [15:0]        height_gain_r = 16'd256;
   logic signed [15:0] height_mem [0:CELLS-1];
   bit                 cell_written [0:CELLS-1];

   height_result_type pending_heights[$];
   int                errors        = 0;
   int                req_gap_pct   = 0;
   int                rsp_stall_pct = 0;
   int                stall_left    = 0;

   heightmap_bilinear_sampler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_world_x      (req_world_x),
      .req_world_z      (req_world_z),
      .req_cell_col     (req_cell_col),
      .req_cell_row     (req_cell_row),
      .req_cell_height  (req_cell_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .rsp_in_bounds    (rsp_in_bounds),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #(CLK_HALF) clock = ~clock;

   // Hard stop in case the design hangs
   initial begin
      #(50_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int side_in_use(logic [7:0] r);
      return (r > hbs_pkg::MAX_SIDE) ? int'(hbs_pkg::MAX_SIDE) : int'(r);
   endfunction

   function automatic longint cell_at(int col, int row);
      return longint'(height_mem[row * int'(hbs_pkg::MAX_SIDE) + col]);
   endfunction

   function automatic bit is_written(int col, int row);
      return cell_written[row * int'(hbs_pkg::MAX_SIDE) + col];
   endfunction

   // Map a sample to grid space; true when it lies inside the grid in use
   function automatic bit grid_point(input terrain_query_type q, output int x0, output int z0,
                                     output longint fx, output longint fz);
      int     w, d;
      longint gx, gz;
      w  = side_in_use(grid_width_r);
      d  = side_in_use(grid_depth_r);
      gx = ((longint'(q.wx) * longint'(inv_scale_r)) >>> 16) + longint'(w) * 128;
      gz = ((longint'(q.wz) * longint'(inv_scale_r)) >>> 16) + longint'(d) * 128;
      x0 = int'(gx >>> 8);
      z0 = int'(gz >>> 8);
      fx = gx & 255;
      fz = gz & 255;
      return w >= 2 && d >= 2 && gx >= 0 && gz >= 0 &&
             gx < longint'(w - 1) * 256 && gz < longint'(d - 1) * 256;
   endfunction

   // Update the store or compute the expected result of one accepted transaction
   task automatic predict_terrain(input terrain_query_type q);
      int                w, d, x0, z0, idx;
      longint            fx, fz, top, bot, acc, val;
      height_result_type r;
      w = side_in_use(grid_width_r);
      d = side_in_use(grid_depth_r);
      idx = int'(q.row) * int'(hbs_pkg::MAX_SIDE) + int'(q.col);
      r.value = '0;
      r.in_bounds = 1'b0;
      if (q.mode == hbs_pkg::MODE_WRITE) begin
         if (int'(q.col) < w && int'(q.row) < d) begin
            height_mem[idx]   = q.height;
            cell_written[idx] = 1'b1;
         end
      end else if (q.mode == hbs_pkg::MODE_READ) begin
         if (int'(q.col) < w && int'(q.row) < d) begin
            val = cell_at(int'(q.col), int'(q.row)) * 16;
            r.value = val[31:0];
            r.in_bounds = 1'b1;
         end
         pending_heights = {pending_heights, r};
      end else if (q.mode == hbs_pkg::MODE_SAMPLE) begin
         if (grid_point(q, x0, z0, fx, fz)) begin
            top = cell_at(x0, z0) * (256 - fx) + cell_at(x0 + 1, z0) * fx;
            bot = cell_at(x0, z0 + 1) * (256 - fx) + cell_at(x0 + 1, z0 + 1) * fx;
            acc = top * (256 - fz) + bot * fz;
            val = (acc * longint'(height_gain_r)) >>> 20;
            r.value = val[31:0];
            r.in_bounds = 1'b1;
         end
         pending_heights = {pending_heights, r};
      end
   endtask

   // True when every cell the transaction reads already holds data
   function automatic bit cells_ready(input terrain_query_type q);
      int     w, d, x0, z0;
      longint fx, fz;
      w = side_in_use(grid_width_r);
      d = side_in_use(grid_depth_r);
      if (q.mode == hbs_pkg::MODE_READ) begin
         if (int'(q.col) < w && int'(q.row) < d)
            return is_written(int'(q.col), int'(q.row));
         return 1'b1;
      end
      if (q.mode == hbs_pkg::MODE_SAMPLE && grid_point(q, x0, z0, fx, fz))
         return is_written(x0, z0) && is_written(x0 + 1, z0) &&
                is_written(x0, z0 + 1) && is_written(x0 + 1, z0 + 1);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Result checker and response stalls
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      height_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_heights.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got value %0d in_bounds %0b",
                     $time, rsp_sample_value, rsp_in_bounds);
         end else begin
            exp_r = pending_heights.pop_front();
            if (rsp_sample_value !== exp_r.value) begin
               errors++;
               $display("%0t: sample_value mismatch, expected %0d, got %0d",
                        $time, exp_r.value, rsp_sample_value);
            end
            if (rsp_in_bounds !== exp_r.in_bounds) begin
               errors++;
               $display("%0t: in_bounds mismatch, expected %0b, got %0b",
                        $time, exp_r.in_bounds, rsp_in_bounds);
            end
         end
      end
      // Hold ready low for a random stall, mostly short
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2, 0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      if ($urandom_range(99) >= req_gap_pct)
         return 0;
      return ($urandom_range(9) == 0) ? $urandom_range(30, 5) : $urandom_range(3, 1);
   endfunction

   function automatic terrain_query_type cell_write(int col, int row, int h);
      terrain_query_type q;
      q = '{hbs_pkg::MODE_WRITE, '0, '0, col[6:0], row[6:0], h[15:0]};
      return q;
   endfunction

   function automatic terrain_query_type cell_read(int col, int row);
      terrain_query_type q;
      q = '{hbs_pkg::MODE_READ, '0, '0, col[6:0], row[6:0], '0};
      return q;
   endfunction

   function automatic terrain_query_type world_sample(int wx, int wz);
      terrain_query_type q;
      q = '{hbs_pkg::MODE_SAMPLE, wx[23:0], wz[23:0], '0, '0, '0};
      return q;
   endfunction

   // Present one transaction and wait for it to be accepted
   task automatic send_item(input terrain_query_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= q.mode;
      req_world_x     <= q.wx;
      req_world_z     <= q.wz;
      req_cell_col    <= q.col;
      req_cell_row    <= q.row;
      req_cell_height <= q.height;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_terrain(q);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input hbs_pkg::csr_reg_type idx, input logic [31:0] value);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         hbs_pkg::CSR_GRID_WIDTH:  grid_width_r  = value[7:0];
         hbs_pkg::CSR_GRID_DEPTH:  grid_depth_r  = value[7:0];
         hbs_pkg::CSR_INV_SCALE:   inv_scale_r   = value[23:0];
         hbs_pkg::CSR_HEIGHT_GAIN: height_gain_r = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(input int w, input int d, input int inv, input int gain);
      write_csr(hbs_pkg::CSR_GRID_WIDTH, w);
      write_csr(hbs_pkg::CSR_GRID_DEPTH, d);
      write_csr(hbs_pkg::CSR_INV_SCALE, inv);
      write_csr(hbs_pkg::CSR_HEIGHT_GAIN, gain);
   endtask

   // Random transaction, mostly aimed at the grid in use
   function automatic terrain_query_type build_query();
      terrain_query_type q;
      int                pick, w, d;
      longint            span;
      w    = side_in_use(grid_width_r);
      d    = side_in_use(grid_depth_r);
      pick = $urandom_range(99);
      q.mode   = (pick < 15) ? hbs_pkg::MODE_WRITE : (pick < 40) ? hbs_pkg::MODE_READ :
                 (pick < 95) ? hbs_pkg::MODE_SAMPLE : hbs_pkg::MODE_NONE;
      q.wx     = 24'($urandom);
      q.wz     = 24'($urandom);
      q.col    = 7'($urandom);
      q.row    = 7'($urandom);
      q.height = 16'($urandom);
      if ((q.mode == hbs_pkg::MODE_WRITE || q.mode == hbs_pkg::MODE_READ) && w > 0 && d > 0 &&
          $urandom_range(4) != 0) begin
         q.col = 7'($urandom_range(w - 1));
         q.row = 7'($urandom_range(d - 1));
      end
      if (q.mode == hbs_pkg::MODE_SAMPLE && $urandom_range(6) != 0) begin
         span = (inv_scale_r == 0) ? 64'd8388607 :
                ((longint'(w > d ? w : d) * 128 + 512) * 65536) / longint'(inv_scale_r);
         if (span > 8388607) span = 8388607;
         if (span < 1) span = 1;
         q.wx = 24'(int'($urandom_range(int'(2 * span))) - int'(span));
         q.wz = 24'(int'($urandom_range(int'(2 * span))) - int'(span));
      end
      return q;
   endfunction

   // Pick a transaction that reads only cells holding data
   function automatic terrain_query_type random_query();
      terrain_query_type q;
      int                tries, w, d;
      for (tries = 0; tries < 20; tries++) begin
         q = build_query();
         if (cells_ready(q)) return q;
      end
      // Fall back to a cell write inside the grid in use, or to no transaction on an empty grid
      w = side_in_use(grid_width_r);
      d = side_in_use(grid_depth_r);
      q.mode = hbs_pkg::MODE_NONE;
      if (w > 0 && d > 0) begin
         q.mode = hbs_pkg::MODE_WRITE;
         q.col  = 7'($urandom_range(w - 1));
         q.row  = 7'($urandom_range(d - 1));
      end
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Write a square block of cells, with extreme heights sprinkled in
   task automatic write_block(input int c0, input int r0, input int n);
      int r, c, h;
      for (r = 0; r < n; r++) begin
         for (c = 0; c < n; c++) begin
            h = int'($urandom);
            if ((r0 + r + c0 + c) % 37 == 0) h = $urandom_range(1) ? 32767 : -32768;
            send_item(cell_write(c0 + c, r0 + r, h));
         end
      end
   endtask

   // Write the corner block and the spots the directed tests touch
   task automatic fill_store();
      req_gap_pct = 10;
      write_block(0, 0, FILL_SIDE);
      write_block(62, 62, 4);
      write_block(124, 124, 4);
      write_block(124, 0, 4);
   endtask

   task automatic test_cell_access();
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      send_item(cell_write(0, 0, -32768));
      send_item(cell_read(0, 0));
      send_item(cell_write(127, 127, 32767));
      send_item(cell_read(127, 127));
      send_item('{hbs_pkg::MODE_NONE, 24'h7FFFFF, 24'h800000, 7'h7F, 7'h7F, 16'hFFFF});
      send_item(cell_write(100, 3, 777));
      // Narrow grid: writes outside are dropped, reads outside return zero
      set_grid(5, 7, 65536, 256);
      send_item(cell_write(100, 3, 1234));
      send_item(cell_write(4, 6, -1));
      send_item(cell_read(4, 6));
      send_item(cell_read(5, 0));
      send_item(cell_read(0, 7));
      set_grid(128, 128, 65536, 256);
      send_item(cell_read(100, 3));
   endtask

   task automatic test_sample_bounds();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      // Grid position is world + 16384 at unit scale on a full grid
      send_item(world_sample(-16384, -16384));
      send_item(world_sample(-16385, 0));
      send_item(world_sample(16127, 16127));
      send_item(world_sample(16128, 0));
      send_item(world_sample(0, 16128));
      send_item(world_sample(-8388608, 8388607));
      // Extreme corners with full gain, then zero gain
      send_item(cell_write(10, 10, 32767));
      send_item(cell_write(11, 10, 32767));
      send_item(cell_write(10, 11, 32767));
      send_item(cell_write(11, 11, -32768));
      set_grid(128, 128, 65536, 65535);
      send_item(world_sample(-13747, -13624));
      set_grid(128, 128, 65536, 0);
      send_item(world_sample(-13747, -13624));
   endtask

   task automatic test_grid_sizes();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      set_grid(0, 0, 65536, 256);
      send_item(cell_read(0, 0));
      send_item(world_sample(0, 0));
      set_grid(1, 1, 65536, 256);
      send_item(cell_read(0, 0));
      send_item(world_sample(-128, -128));
      set_grid(2, 2, 65536, 256);
      send_item(world_sample(-256, -1));
      send_item(world_sample(0, -256));
      // Oversized registers act as the maximum side
      set_grid(200, 255, 1, 256);
      send_item(world_sample(8388607, -8388608));
      send_item(cell_read(127, 127));
      set_grid(128, 128, 24'hFFFFFF, 65535);
      send_item(world_sample(63, -64));
      send_item(world_sample(64, 0));
   endtask

   task automatic run_traffic_phase(input int w, input int d, input int inv, input int gain,
                                    input int count, input int gap_pct, input int stall_pct,
                                    input bit drain_mid);
      int i;
      set_grid(w, d, inv, gain);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (i = 0; i < count; i++) begin
         // Pause the sender until everything in flight has returned
         if (drain_mid && i == count / 2) wait_drained();
         send_item(random_query());
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(FILL_SIDE, FILL_SIDE, 65536, 256, 220, 0, 0, 1'b0);
      run_traffic_phase(2, 2, 65536, 65535, 150, 40, 40, 1'b0);
      run_traffic_phase(255, 200, 1, 0, 150, 20, 10, 1'b0);
      run_traffic_phase(0, 1, 32768, 256, 80, 30, 30, 1'b0);
      run_traffic_phase($urandom_range(FILL_SIDE, 2), $urandom_range(FILL_SIDE, 2),
                        $urandom_range(24'hFFFFFF, 1), $urandom_range(65535), 200, 30, 30, 1'b1);
      run_traffic_phase(17, 19, 24'hFFFFFF, $urandom_range(65535), 150, 10, 50, 1'b0);
      run_traffic_phase(FILL_SIDE, 3, $urandom_range(1 << 20, 1 << 12), 65535, 150, 50, 10,
                        1'b0);
      run_traffic_phase($urandom_range(255), $urandom_range(255), $urandom_range(24'hFFFFFF),
                        $urandom_range(65535), 150, 25, 25, 1'b0);
      run_traffic_phase(16, FILL_SIDE, 131072, $urandom_range(65535), 200, 0, 60, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fill_store();
      test_cell_access();
      test_sample_bounds();
      test_grid_sizes();
      test_random_traffic();
      wait_drained();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: heightmap_bilinear_sampler.f
rtl/core/hbs_pkg.sv
rtl/core/hbs_ram.sv
rtl/core/hbs_store.sv
rtl/core/hbs_interp.sv
rtl/core/heightmap_bilinear_sampler.sv
rtl/core/hbs_checker.sv
sim/tb.sv
